### rtl/cbc_pkg.sv
// ----------------------------------------------------------------------------
// cbc_pkg
// Shared types, register codes and fixed-point helpers for the cascaded
// balance controller.
// ----------------------------------------------------------------------------
package cbc_pkg;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 24;
  localparam int unsigned GAIN_W     = 24;
  localparam int unsigned RATE_W     = 16;
  localparam int unsigned MUL_A_W    = 34;
  localparam int unsigned MUL_B_W    = 25;
  localparam int unsigned PROD_W     = MUL_A_W + MUL_B_W;
  localparam int unsigned ACC_W      = 64;

  // smoothing weights (0.92 / 0.08, 16 fraction bits)
  localparam logic [RATE_W-1:0] SMOOTH_KEEP = 16'd60293;
  localparam logic [RATE_W-1:0] SMOOTH_NEW  = 16'd5243;

  // setpoint after reset: minus three degrees
  localparam logic signed [31:0] SETPOINT_RESET = -32'sd768;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ANGLE_GAIN_P   = 3'd0,
    REG_ANGLE_GAIN_D   = 3'd1,
    REG_ANGLE_GAIN_I   = 3'd2,
    REG_SPEED_GAIN_P   = 3'd3,
    REG_SPEED_GAIN_I   = 3'd4,
    REG_TICK_PERIOD    = 3'd5,
    REG_TICK_RATE      = 3'd6,
    REG_INTEGRAL_LIMIT = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic [GAIN_W-1:0] angle_gain_p;
    logic [GAIN_W-1:0] angle_gain_d;
    logic [GAIN_W-1:0] angle_gain_i;
    logic [GAIN_W-1:0] speed_gain_p;
    logic [GAIN_W-1:0] speed_gain_i;
    logic [RATE_W-1:0] tick_period;
    logic [RATE_W-1:0] tick_rate;
    logic [GAIN_W-1:0] integral_limit;
  } cfg_t;

  // one command word for the shared multiply-accumulate unit
  typedef struct packed {
    logic                      valid;
    logic                      clear;
    logic signed [MUL_A_W-1:0] a;
    logic signed [MUL_B_W-1:0] b;
  } mac_cmd_t;

  // saturate a wide signed value to signed 32 bits
  function automatic logic signed [31:0] sat32(input logic signed [ACC_W-1:0] x);
    logic hi_same;
    hi_same = (&x[ACC_W-1:31]) | ~(|x[ACC_W-1:31]);
    if (hi_same) begin
      sat32 = x[31:0];
    end else if (x[ACC_W-1]) begin
      sat32 = {1'b1, 31'b0};
    end else begin
      sat32 = {1'b0, {31{1'b1}}};
    end
  endfunction

  // floor(x / 2^16), then saturate to signed 32 bits
  function automatic logic signed [31:0] sat_shr16(input logic signed [ACC_W-1:0] x);
    logic signed [ACC_W-1:0] t;
    t = x >>> 16;
    sat_shr16 = sat32(t);
  endfunction

  // sign-extend a 34-bit value to the accumulator width
  function automatic logic signed [ACC_W-1:0] ext34(input logic signed [33:0] x);
    ext34 = {{(ACC_W-34){x[33]}}, x};
  endfunction

  // sign-extend a 32-bit signal to the multiplier A width
  function automatic logic signed [MUL_A_W-1:0] ext_a(input logic signed [31:0] x);
    ext_a = {{(MUL_A_W-32){x[31]}}, x};
  endfunction

endpackage

### rtl/cascaded_balance_controller_unit.sv
// ----------------------------------------------------------------------------
// cascaded_balance_controller_unit
// Cascaded angle PID / speed PI balance controller, one tick per input word.
// ----------------------------------------------------------------------------
// Each input word is one control tick. The result word is loaded into the
// output register in the final step, and the next input can be taken in the
// cycle after that load. The tick length is set by the single shared
// 34x25 multiplier with its registered multiply and accumulate stages, which
// serves all ten products of the tick in sequence. A finished result waits
// in the output register while the next tick is accepted; a tick that
// completes before the old result is taken holds in its last step.
module cascaded_balance_controller_unit (
  input  logic                           clk,
  input  logic                           rst,
  // input channel
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic signed [16:0]             tilt_angle,
  input  logic signed [15:0]             target_speed,
  input  logic signed [16:0]             steer_offset,
  // result channel
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic signed [31:0]             left_drive,
  output logic signed [31:0]             right_drive,
  output logic signed [31:0]             balance_drive,
  // configuration channel
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [cbc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [cbc_pkg::CFG_DATA_W-1:0] cfg_data
);
  import cbc_pkg::*;

  typedef enum logic [19:0] {
    S_IDLE = 20'h00001,
    S_DER  = 20'h00002,
    S_INC  = 20'h00004,
    S_DERS = 20'h00008,
    S_INTG = 20'h00010,
    S_GI   = 20'h00020,
    S_W1   = 20'h00040,
    S_BAL  = 20'h00080,
    S_EST1 = 20'h00100,
    S_EST2 = 20'h00200,
    S_W2   = 20'h00400,
    S_EST  = 20'h00800,
    S_VERR = 20'h01000,
    S_SUM1 = 20'h02000,
    S_SP1  = 20'h04000,
    S_SUM  = 20'h08000,
    S_SP2  = 20'h10000,
    S_W3   = 20'h20000,
    S_SET  = 20'h40000,
    S_OUT  = 20'h80000
  } state_t;

  state_t                   state, state_next;
  cfg_t                     cfg;
  mac_cmd_t                 mac_cmd;
  logic signed [ACC_W-1:0]  acc;

  // controller state
  logic signed [31:0] previous_error;
  logic signed [31:0] angle_integral;
  logic signed [31:0] speed_estimate;
  logic signed [31:0] speed_error_sum;
  logic signed [31:0] angle_setpoint;

  // per-tick working registers
  logic signed [16:0] steer;
  logic signed [23:0] target;
  logic signed [31:0] err;
  logic signed [31:0] deriv;
  logic signed [31:0] balance;
  logic signed [31:0] verr;

  logic               in_take;
  logic               out_load;
  logic signed [33:0] err_wide;
  logic signed [33:0] diff;
  logic signed [33:0] inc_wide;
  logic signed [33:0] trial;
  logic signed [33:0] mag;
  logic signed [31:0] inc;
  logic signed [33:0] verr_wide;
  logic signed [33:0] sum_wide;
  logic signed [33:0] left_wide;
  logic signed [33:0] right_wide;

  cbc_regs u_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  cbc_mac u_mac (
    .clk (clk),
    .rst (rst),
    .cmd (mac_cmd),
    .acc (acc)
  );

  // handshake
  assign in_stall = (state != S_IDLE);
  assign in_take  = in_valid & ~in_stall;
  assign out_load = (state == S_OUT) & ~(out_valid & out_stall);

  // small adders around the shared unit
  assign err_wide   = -{{17{tilt_angle[16]}}, tilt_angle}
                      - {{2{angle_setpoint[31]}}, angle_setpoint};
  assign diff       = {{2{err[31]}}, err} - {{2{previous_error[31]}}, previous_error};
  assign inc        = sat_shr16(acc);
  assign inc_wide   = {{2{inc[31]}}, inc};
  assign trial      = {{2{angle_integral[31]}}, angle_integral} + inc_wide;
  assign mag        = trial[33] ? -trial : trial;
  assign verr_wide  = {{10{target[23]}}, target}
                      - {{2{speed_estimate[31]}}, speed_estimate};
  assign sum_wide   = {{2{speed_error_sum[31]}}, speed_error_sum} + inc_wide;
  assign left_wide  = -{{2{balance[31]}}, balance} + {{17{steer[16]}}, steer};
  assign right_wide = {{2{balance[31]}}, balance} + {{17{steer[16]}}, steer};

  // sequence the shared multiplier
  always_comb begin
    mac_cmd    = '0;
    state_next = state;
    case (state)
      S_IDLE: if (in_take) state_next = S_DER;
      S_DER: begin
        mac_cmd = '{valid: 1'b1, clear: 1'b1, a: diff,
                    b: {9'b0, cfg.tick_rate}};
        state_next = S_INC;
      end
      S_INC: begin
        mac_cmd = '{valid: 1'b1, clear: 1'b1, a: ext_a(err),
                    b: {9'b0, cfg.tick_period}};
        state_next = S_DERS;
      end
      S_DERS: begin
        mac_cmd = '{valid: 1'b1, clear: 1'b1, a: ext_a(err),
                    b: {1'b0, cfg.angle_gain_p}};
        state_next = S_INTG;
      end
      S_INTG: begin
        mac_cmd = '{valid: 1'b1, clear: 1'b0, a: ext_a(deriv),
                    b: {1'b0, cfg.angle_gain_d}};
        state_next = S_GI;
      end
      S_GI: begin
        mac_cmd = '{valid: 1'b1, clear: 1'b0, a: ext_a(angle_integral),
                    b: {1'b0, cfg.angle_gain_i}};
        state_next = S_W1;
      end
      S_W1:  state_next = S_BAL;
      S_BAL: state_next = S_EST1;
      S_EST1: begin
        mac_cmd = '{valid: 1'b1, clear: 1'b1, a: ext_a(speed_estimate),
                    b: {9'b0, SMOOTH_KEEP}};
        state_next = S_EST2;
      end
      S_EST2: begin
        mac_cmd = '{valid: 1'b1, clear: 1'b0, a: ext_a(balance),
                    b: {9'b0, SMOOTH_NEW}};
        state_next = S_W2;
      end
      S_W2:   state_next = S_EST;
      S_EST:  state_next = S_VERR;
      S_VERR: state_next = S_SUM1;
      S_SUM1: begin
        mac_cmd = '{valid: 1'b1, clear: 1'b1, a: ext_a(verr),
                    b: {9'b0, cfg.tick_period}};
        state_next = S_SP1;
      end
      S_SP1: begin
        mac_cmd = '{valid: 1'b1, clear: 1'b1, a: ext_a(verr),
                    b: {1'b0, cfg.speed_gain_p}};
        state_next = S_SUM;
      end
      S_SUM: state_next = S_SP2;
      S_SP2: begin
        mac_cmd = '{valid: 1'b1, clear: 1'b0, a: ext_a(speed_error_sum),
                    b: {1'b0, cfg.speed_gain_i}};
        state_next = S_W3;
      end
      S_W3:  state_next = S_SET;
      S_SET: state_next = S_OUT;
      S_OUT: if (out_load) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // controller state updates
  always_ff @(posedge clk) begin
    if (rst) begin
      previous_error  <= '0;
      angle_integral  <= '0;
      speed_estimate  <= '0;
      speed_error_sum <= '0;
      angle_setpoint  <= SETPOINT_RESET;
    end else begin
      case (state)
        S_INTG: begin
          if (mag <= {10'b0, cfg.integral_limit}) angle_integral <= trial[31:0];
        end
        S_BAL:  previous_error  <= err;
        S_EST:  speed_estimate  <= sat_shr16(acc);
        S_SUM:  speed_error_sum <= sat32(ext34(sum_wide));
        S_SET:  angle_setpoint  <= sat_shr16(acc);
        default: ;
      endcase
    end
  end

  // capture the input word and per-tick values
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (in_take) begin
          err    <= sat32(ext34(err_wide));
          target <= {target_speed, 8'b0};
          steer  <= steer_offset;
        end
      end
      S_DERS: deriv   <= sat32(acc);
      S_BAL:  balance <= sat_shr16(acc);
      S_VERR: verr    <= sat32(ext34(verr_wide));
      default: ;
    endcase
  end

  // result register: load when free, drop when taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      left_drive    <= sat32(ext34(left_wide));
      right_drive   <= sat32(ext34(right_wide));
      balance_drive <= balance;
    end
  end

  // checks
  a_busy_after_take: assert property (@(posedge clk) disable iff (rst)
    in_take |=> in_stall)
    else $error("input not stalled after a word was taken");

  a_out_load: assert property (@(posedge clk) disable iff (rst)
    out_load |=> (out_valid && state == S_IDLE))
    else $error("result not presented after final step");

  a_valid_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == S_OUT))
    else $error("result valid raised outside final step");

endmodule

### rtl/cbc_regs.sv
// ----------------------------------------------------------------------------
// cbc_regs
// Configuration register file: gains, tick period and rate, integral limit.
// ----------------------------------------------------------------------------
module cbc_regs (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [cbc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [cbc_pkg::CFG_DATA_W-1:0] cfg_data,
  output cbc_pkg::cfg_t                  cfg
);
  import cbc_pkg::*;

  logic do_write;

  // always take a word
  assign cfg_ready = 1'b1;
  assign do_write  = cfg_valid & cfg_ready;

  // write the addressed register, narrow ones keep the low bits
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.angle_gain_p   <= 24'd1310720;
      cfg.angle_gain_d   <= 24'd3277;
      cfg.angle_gain_i   <= 24'd3276800;
      cfg.speed_gain_p   <= 24'd2621;
      cfg.speed_gain_i   <= 24'd459;
      cfg.tick_period    <= 16'd655;
      cfg.tick_rate      <= 16'd100;
      cfg.integral_limit <= 24'd153600;
    end else if (do_write) begin
      case (reg_idx_t'(cfg_index))
        REG_ANGLE_GAIN_P:   cfg.angle_gain_p   <= cfg_data;
        REG_ANGLE_GAIN_D:   cfg.angle_gain_d   <= cfg_data;
        REG_ANGLE_GAIN_I:   cfg.angle_gain_i   <= cfg_data;
        REG_SPEED_GAIN_P:   cfg.speed_gain_p   <= cfg_data;
        REG_SPEED_GAIN_I:   cfg.speed_gain_i   <= cfg_data;
        REG_TICK_PERIOD:    cfg.tick_period    <= cfg_data[RATE_W-1:0];
        REG_TICK_RATE:      cfg.tick_rate      <= cfg_data[RATE_W-1:0];
        REG_INTEGRAL_LIMIT: cfg.integral_limit <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

### rtl/cbc_mac.sv
// ----------------------------------------------------------------------------
// cbc_mac
// Shared multiply-accumulate unit: a registered 34x25 signed product, then
// a 64-bit accumulate. A command's result passes the product register, then acc.
// ----------------------------------------------------------------------------
module cbc_mac (
  input  logic                                 clk,
  input  logic                                 rst,
  input  cbc_pkg::mac_cmd_t                    cmd,
  output logic signed [cbc_pkg::ACC_W-1:0]     acc
);
  import cbc_pkg::*;

  logic signed [PROD_W-1:0] prod;
  logic                     pend;
  logic                     pend_clear;

  // multiply stage
  always_ff @(posedge clk) begin
    prod <= $signed(cmd.a) * $signed(cmd.b);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend       <= 1'b0;
      pend_clear <= 1'b0;
    end else begin
      pend       <= cmd.valid;
      pend_clear <= cmd.clear;
    end
  end

  // accumulate stage: clear or add
  always_ff @(posedge clk) begin
    if (pend) begin
      acc <= (pend_clear ? '0 : acc) + {{(ACC_W-PROD_W){prod[PROD_W-1]}}, prod};
    end
  end

endmodule

### test/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives control ticks into the cascaded balance controller and checks every
// result word against an in-bench fixed-point model of the angle PID and the
// speed PI loop, across several register settings including both extremes.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import cbc_pkg::*;

  localparam longint KEEP_WEIGHT    = 60293;
  localparam longint NEW_WEIGHT     = 5243;
  localparam int     SETPOINT_START = -768;
  localparam int     STALL_LIMIT    = 3000;
  localparam int     LONG_HOLD      = 300;

  typedef struct packed {
    logic signed [16:0] tilt;
    logic signed [15:0] target;
    logic signed [16:0] steer;
  } tick_t;

  typedef struct packed {
    logic signed [31:0] left_drv;
    logic signed [31:0] right_drv;
    logic signed [31:0] bal_drv;
  } drive_t;

  typedef enum {SET_RESET, SET_MAX, SET_ZERO, SET_MILD, SET_WIDE, SET_CORNER} setting_t;

  logic               clk           = 1'b0;
  logic               rst           = 1'b1;
  logic               in_valid      = 1'b0;
  logic               in_stall;
  logic signed [16:0] tilt_angle    = '0;
  logic signed [15:0] target_speed  = '0;
  logic signed [16:0] steer_offset  = '0;
  logic               out_valid;
  logic               out_stall     = 1'b0;
  logic signed [31:0] left_drive;
  logic signed [31:0] right_drive;
  logic signed [31:0] balance_drive;
  logic               cfg_valid     = 1'b0;
  logic               cfg_ready;
  logic [2:0]         cfg_index     = '0;
  logic [23:0]        cfg_data      = '0;

  // register mirror and controller state
  cfg_t               ctl_cfg;
  logic signed [31:0] prev_err      = '0;
  logic signed [31:0] ang_int       = '0;
  logic signed [31:0] spd_est       = '0;
  logic signed [31:0] spd_err_sum   = '0;
  logic signed [31:0] ang_setpoint  = SETPOINT_START;

  tick_t  tick_queue[$];
  drive_t expected_drives[$];
  logic   in_fire       = 1'b0;
  int     idle_pct      = 7;
  int     mismatches    = 0;
  int     quiet_cycles  = 0;
  logic   rx_hold_ask   = 1'b0;
  logic   rx_hold_used  = 1'b0;
  int     rx_hold_left  = 0;

  cascaded_balance_controller_unit dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .tilt_angle    (tilt_angle),
    .target_speed  (target_speed),
    .steer_offset  (steer_offset),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .left_drive    (left_drive),
    .right_drive   (right_drive),
    .balance_drive (balance_drive),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic logic signed [31:0] clip32(longint x);
    if (x > longint'(2147483647)) return 32'sh7fffffff;
    if (x < -longint'(2147483647) - 1) return 32'sh80000000;
    return 32'(x);
  endfunction

  function automatic logic [23:0] reset_value(reg_idx_t idx);
    case (idx)
      REG_ANGLE_GAIN_P: return 24'd1310720;
      REG_ANGLE_GAIN_D: return 24'd3277;
      REG_ANGLE_GAIN_I: return 24'd3276800;
      REG_SPEED_GAIN_P: return 24'd2621;
      REG_SPEED_GAIN_I: return 24'd459;
      REG_TICK_PERIOD:  return 24'd655;
      REG_TICK_RATE:    return 24'd100;
      default:          return 24'd153600;
    endcase
  endfunction

  // advance the controller by one tick and return the drives it produces
  function automatic drive_t run_tick(tick_t t);
    longint             tilt, target, steer, inc, trial, mag, acc;
    logic signed [31:0] err, deriv, bal, verr;
    drive_t             d;
    tilt   = longint'(t.tilt);
    target = longint'(t.target) * 256;
    steer  = longint'(t.steer);

    // angle PID; the integral keeps its old value when the step overshoots
    err   = clip32(-tilt - longint'(ang_setpoint));
    deriv = clip32((longint'(err) - longint'(prev_err)) * longint'(ctl_cfg.tick_rate));
    inc   = (longint'(err) * longint'(ctl_cfg.tick_period)) >>> 16;
    trial = longint'(ang_int) + inc;
    mag   = (trial < 0) ? -trial : trial;
    if (mag <= longint'(ctl_cfg.integral_limit)) ang_int = 32'(trial);
    acc = longint'(err) * longint'(ctl_cfg.angle_gain_p)
        + longint'(deriv) * longint'(ctl_cfg.angle_gain_d)
        + longint'(ang_int) * longint'(ctl_cfg.angle_gain_i);
    bal      = clip32(acc >>> 16);
    prev_err = err;

    // speed PI feeding the setpoint of the next tick
    spd_est = clip32((longint'(spd_est) * KEEP_WEIGHT + longint'(bal) * NEW_WEIGHT) >>> 16);
    verr    = clip32(target - longint'(spd_est));
    spd_err_sum = clip32(longint'(spd_err_sum)
                  + ((longint'(verr) * longint'(ctl_cfg.tick_period)) >>> 16));
    ang_setpoint = clip32((longint'(verr) * longint'(ctl_cfg.speed_gain_p)
                   + longint'(spd_err_sum) * longint'(ctl_cfg.speed_gain_i)) >>> 16);

    d.left_drv  = clip32(steer - longint'(bal));
    d.right_drv = clip32(steer + longint'(bal));
    d.bal_drv   = bal;
    return d;
  endfunction

  function automatic tick_t make_tick(int tilt, int target, int steer);
    tick_t t;
    t.tilt   = 17'(tilt);
    t.target = 16'(target);
    t.steer  = 17'(steer);
    return t;
  endfunction

  // mostly near-balance ticks, with full-range ones mixed in
  function automatic tick_t rand_tick();
    tick_t t;
    if ($urandom_range(99) < 60) t.tilt = 17'(int'($urandom_range(4000)) - 2000);
    else t.tilt = 17'(int'($urandom_range(92160)) - 46080);
    if ($urandom_range(1) == 1) t.target = 16'(int'($urandom_range(128)) - 64);
    else t.target = 16'($urandom);
    if ($urandom_range(1) == 1) t.steer = 17'(int'($urandom_range(2048)) - 1024);
    else t.steer = 17'($urandom);
    return t;
  endfunction

  task automatic check_field(string what, logic signed [31:0] want, logic signed [31:0] got);
    if (want !== got) begin
      mismatches++;
      if (mismatches <= 10)
        $display("%0t: %s mismatch, expected %0d, got %0d", $realtime, what, want, got);
    end
  endtask

  task automatic write_reg(reg_idx_t idx, logic [23:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_ANGLE_GAIN_P:   ctl_cfg.angle_gain_p   = val;
      REG_ANGLE_GAIN_D:   ctl_cfg.angle_gain_d   = val;
      REG_ANGLE_GAIN_I:   ctl_cfg.angle_gain_i   = val;
      REG_SPEED_GAIN_P:   ctl_cfg.speed_gain_p   = val;
      REG_SPEED_GAIN_I:   ctl_cfg.speed_gain_i   = val;
      REG_TICK_PERIOD:    ctl_cfg.tick_period    = val[15:0];
      REG_TICK_RATE:      ctl_cfg.tick_rate      = val[15:0];
      REG_INTEGRAL_LIMIT: ctl_cfg.integral_limit = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // write all eight registers for one setting
  task automatic program_phase(setting_t kind);
    logic [23:0] val;
    reg_idx_t    idx;
    for (int i = 0; i < 8; i++) begin
      idx = reg_idx_t'(i);
      case (kind)
        SET_RESET: val = reset_value(idx);
        SET_MAX:   val = '1;
        SET_ZERO:  val = '0;
        SET_WIDE:  val = 24'($urandom);
        SET_MILD: begin
          case (idx)
            REG_ANGLE_GAIN_P:   val = 24'($urandom_range(1 << 22));
            REG_ANGLE_GAIN_D:   val = 24'($urandom_range(1 << 16));
            REG_ANGLE_GAIN_I:   val = 24'($urandom_range(1 << 23));
            REG_TICK_PERIOD:    val = 24'($urandom_range(4000, 1));
            REG_TICK_RATE:      val = 24'($urandom_range(1000, 1));
            REG_INTEGRAL_LIMIT: val = 24'($urandom_range(1 << 20));
            default:            val = 24'($urandom_range(1 << 14));
          endcase
        end
        default: begin
          case ($urandom_range(2))
            0:       val = '0;
            1:       val = '1;
            default: val = reset_value(idx);
          endcase
        end
      endcase
      write_reg(idx, val);
    end
    @(posedge clk);
  endtask

  // random ticks, with runs of one held tilt to wind the integral up
  task automatic queue_random(int count);
    tick_t t;
    int    run;
    while (count > 0) begin
      if ($urandom_range(9) == 0) begin
        t   = rand_tick();
        run = $urandom_range(20, 8);
        repeat (run) tick_queue.push_back(t);
        count -= run;
      end else begin
        tick_queue.push_back(rand_tick());
        count--;
      end
    end
  endtask

  task automatic wait_drained();
    while (tick_queue.size() != 0 || in_valid || expected_drives.size() != 0)
      @(posedge clk);
  endtask

  // input driver: offer the next word once the current one is taken
  always @(negedge clk) begin
    tick_t word;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_fire) begin
      if (tick_queue.size() != 0 && $urandom_range(99) >= idle_pct) begin
        word = tick_queue.pop_front();
        tilt_angle   <= word.tilt;
        target_speed <= word.target;
        steer_offset <= word.steer;
        in_valid     <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result receiver: random stalls plus one long hold-off on request
  always @(negedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (rx_hold_ask && !rx_hold_used) begin
        rx_hold_left = LONG_HOLD;
        rx_hold_used = 1'b1;
      end
      if (rx_hold_left > 0) begin
        rx_hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < idle_pct);
      end
    end
  end

  // monitor: predict on every accepted tick, compare every accepted result
  always @(posedge clk) begin
    drive_t want;
    if (rst) begin
      in_fire <= 1'b0;
    end else begin
      in_fire <= in_valid && !in_stall;
      if (out_valid && !out_stall) begin
        if (expected_drives.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("%0t: result word with none expected", $realtime);
        end else begin
          want = expected_drives.pop_front();
          check_field("left_drive", want.left_drv, left_drive);
          check_field("right_drive", want.right_drv, right_drive);
          check_field("balance_drive", want.bal_drv, balance_drive);
        end
      end
      if (in_valid && !in_stall)
        expected_drives.push_back(run_tick('{tilt_angle, target_speed, steer_offset}));
    end
  end

  // watchdog: end the run when nothing moves for too long
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == STALL_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    setting_t kind;
    int       n;
    for (int i = 0; i < 8; i++) begin
      case (reg_idx_t'(i))
        REG_ANGLE_GAIN_P:   ctl_cfg.angle_gain_p   = reset_value(REG_ANGLE_GAIN_P);
        REG_ANGLE_GAIN_D:   ctl_cfg.angle_gain_d   = reset_value(REG_ANGLE_GAIN_D);
        REG_ANGLE_GAIN_I:   ctl_cfg.angle_gain_i   = reset_value(REG_ANGLE_GAIN_I);
        REG_SPEED_GAIN_P:   ctl_cfg.speed_gain_p   = reset_value(REG_SPEED_GAIN_P);
        REG_SPEED_GAIN_I:   ctl_cfg.speed_gain_i   = reset_value(REG_SPEED_GAIN_I);
        REG_TICK_PERIOD:    ctl_cfg.tick_period    = reset_value(REG_TICK_PERIOD);
        REG_TICK_RATE:      ctl_cfg.tick_rate      = reset_value(REG_TICK_RATE);
        default:            ctl_cfg.integral_limit = reset_value(REG_INTEGRAL_LIMIT);
      endcase
    end
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // field extremes at the reset settings
    tick_queue.push_back(make_tick(46080, 32767, 65535));
    tick_queue.push_back(make_tick(-46080, -32768, -65536));
    tick_queue.push_back(make_tick(0, 0, 0));
    tick_queue.push_back(make_tick(46080, -32768, 65535));
    tick_queue.push_back(make_tick(-46080, 32767, -65536));
    tick_queue.push_back(make_tick(256, 1, -1));
    tick_queue.push_back(make_tick(-1, -1, 1));
    tick_queue.push_back(make_tick(0, 32767, 0));
    wait_drained();

    // integral clamp: a tight limit, a held tilt, then the other way
    write_reg(REG_INTEGRAL_LIMIT, 24'd600);
    @(posedge clk);
    repeat (6) tick_queue.push_back(make_tick(-20000, 0, 0));
    repeat (2) tick_queue.push_back(make_tick(20000, 0, 0));
    wait_drained();

    // all registers at their top, then all at zero (no integral, no derivative)
    for (int k = 0; k < 2; k++) begin
      program_phase(k == 0 ? SET_MAX : SET_ZERO);
      tick_queue.push_back(make_tick(46080, 32767, 65535));
      tick_queue.push_back(make_tick(-46080, -32768, -65536));
      tick_queue.push_back(make_tick(46080, -32768, -65536));
      tick_queue.push_back(make_tick(-46080, 32767, 65535));
      wait_drained();
    end

    // random phases over several settings
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0:       kind = SET_RESET;
        1:       kind = SET_MILD;
        2:       kind = SET_WIDE;
        3:       kind = SET_CORNER;
        4:       kind = SET_RESET;
        default: kind = SET_MILD;
      endcase
      program_phase(kind);
      idle_pct = (ph == 0) ? 0 : 7;
      n = (ph == 4) ? 65 : 130;
      queue_random(n);
      if (ph == 1) begin
        // hold the receiver off while words keep coming
        while (tick_queue.size() > n - 10) @(posedge clk);
        rx_hold_ask = 1'b1;
      end
      if (ph == 4) begin
        // pause the sender until every result is back
        wait_drained();
        queue_random(n);
      end
      wait_drained();
    end

    repeat (40) @(posedge clk);
    if (expected_drives.size() != 0) begin
      mismatches++;
      $display("%0d result words never arrived", expected_drives.size());
    end
    if (mismatches == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule
